@@ hw/rtl/cled_pkg.sv @@
// Shared types, character codes and digit helpers for the escape decoder.
`default_nettype none

package cled_pkg;

    // Decode phase, one-hot.
    typedef enum logic [6:0] {
        PH_IDLE = 7'b0000001,
        PH_ESC  = 7'b0000010,
        PH_OCT1 = 7'b0000100,
        PH_OCT2 = 7'b0001000,
        PH_OCT3 = 7'b0010000,
        PH_HEX1 = 7'b0100000,
        PH_HEX2 = 7'b1000000
    } t_phase;

    typedef logic [7:0] t_byte;

    localparam t_byte CH_BSLASH = 8'h5C;
    localparam t_byte CH_ZERO   = 8'h30;
    localparam t_byte CH_THREE  = 8'h33;
    localparam t_byte CH_SEVEN  = 8'h37;
    localparam t_byte CH_NINE   = 8'h39;
    localparam t_byte CH_X      = 8'h78;
    localparam t_byte CH_LC_A   = 8'h61;
    localparam t_byte CH_LC_B   = 8'h62;
    localparam t_byte CH_LC_F   = 8'h66;
    localparam t_byte CH_LC_N   = 8'h6E;
    localparam t_byte CH_LC_R   = 8'h72;
    localparam t_byte CH_LC_T   = 8'h74;
    localparam t_byte CH_LC_V   = 8'h76;
    localparam t_byte CH_UC_A   = 8'h41;
    localparam t_byte CH_UC_F   = 8'h46;

    // Result of a hex digit lookup.
    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_digit(input t_byte b);
        t_hex r;
        r.ok    = 1'b1;
        r.value = 4'd0;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            r.value = b[3:0];
        end else if ((b >= CH_LC_A && b <= CH_LC_F) || (b >= CH_UC_A && b <= CH_UC_F)) begin
            // 'a'/'A' have low nibble 1: add 9 to land on 10.
            r.value = b[3:0] + 4'd9;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    function automatic t_byte named_escape(input t_byte b);
        t_byte r;
        unique case (b)
            CH_LC_A: r = 8'd7;
            CH_LC_B: r = 8'd8;
            CH_LC_F: r = 8'd12;
            CH_LC_N: r = 8'd10;
            CH_LC_R: r = 8'd13;
            CH_LC_T: r = 8'd9;
            CH_LC_V: r = 8'd11;
            default: r = b;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/char_literal_escape_decoder_unit.sv @@
// Character-literal escape decoder: byte stream in, decoded characters out.
//
// Usage:
//   Input channel  (i_in_valid / o_in_ready, i_source_byte): raw bytes of a
//   character-literal body, one transaction per byte.
//   Output channel (o_out_valid / i_out_ready, o_decoded_byte, o_bad_escape):
//   one transaction per finished character. Backslash, escape prefixes and
//   leading digits of an escape produce no output transaction.
//   A bad octal or hex digit consumes that byte and yields value 0 with
//   o_bad_escape set; decoding then restarts from plain text.
// Pipeline and rate:
//   A byte lands in the input register, is decoded against the phase and
//   digit accumulator in shallow combinational logic, and its character is
//   then written to the result register, which drives the output channel.
//   One byte per cycle is sustained while the result register is not stalled;
//   the single phase/accumulator update per cycle sets that.
// Stall behavior:
//   While the result register holds an untaken character, a byte that
//   yields a character waits in the input register; bytes that yield no
//   character still drain. o_in_ready follows i_out_ready combinationally.
// Reset:
//   i_rst_n (synchronous, active low) empties both registers and returns
//   the decoder to plain-text phase with a cleared accumulator.
`default_nettype none

module char_literal_escape_decoder_unit (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire cled_pkg::t_byte i_source_byte,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output cled_pkg::t_byte     o_decoded_byte,
    output logic                o_bad_escape
);
    import cled_pkg::*;

    // Input register
    logic   r_in_valid;
    t_byte  r_in_byte;

    // Decode state
    t_phase r_phase, n_phase;
    t_byte  r_acc, n_acc;

    // Result register
    logic   r_out_valid;
    t_byte  r_out_byte;
    logic   r_out_bad;

    // Decode outputs
    logic   emit;
    t_byte  emit_byte;
    logic   emit_bad;
    t_hex   hex;
    logic   advance;

    assign hex = hex_digit(r_in_byte);

    always_comb begin
        emit      = 1'b0;
        emit_byte = '0;
        emit_bad  = 1'b0;
        n_phase   = r_phase;
        n_acc     = r_acc;
        unique case (r_phase)
            PH_ESC: begin
                if (r_in_byte == CH_ZERO) begin
                    n_phase = PH_OCT1;
                    n_acc   = '0;
                end else if (r_in_byte == CH_X) begin
                    n_phase = PH_HEX1;
                    n_acc   = '0;
                end else begin
                    emit      = 1'b1;
                    emit_byte = named_escape(r_in_byte);
                end
            end
            PH_OCT1: begin
                if (r_in_byte >= CH_ZERO && r_in_byte <= CH_THREE) begin
                    n_acc   = {6'd0, r_in_byte[1:0]};
                    n_phase = PH_OCT2;
                end else begin
                    emit     = 1'b1;
                    emit_bad = 1'b1;
                end
            end
            PH_OCT2: begin
                if (r_in_byte >= CH_ZERO && r_in_byte <= CH_SEVEN) begin
                    n_acc   = {r_acc[4:0], r_in_byte[2:0]};
                    n_phase = PH_OCT3;
                end else begin
                    emit     = 1'b1;
                    emit_bad = 1'b1;
                end
            end
            PH_OCT3: begin
                emit = 1'b1;
                if (r_in_byte >= CH_ZERO && r_in_byte <= CH_SEVEN) begin
                    emit_byte = {r_acc[4:0], r_in_byte[2:0]};
                end else begin
                    emit_bad = 1'b1;
                end
            end
            PH_HEX1: begin
                if (hex.ok) begin
                    n_acc   = {4'd0, hex.value};
                    n_phase = PH_HEX2;
                end else begin
                    emit     = 1'b1;
                    emit_bad = 1'b1;
                end
            end
            PH_HEX2: begin
                emit = 1'b1;
                if (hex.ok) begin
                    emit_byte = {r_acc[3:0], hex.value};
                end else begin
                    emit_bad = 1'b1;
                end
            end
            default: begin
                // Plain text
                if (r_in_byte == CH_BSLASH) begin
                    n_phase = PH_ESC;
                    n_acc   = '0;
                end else begin
                    emit      = 1'b1;
                    emit_byte = r_in_byte;
                end
            end
        endcase
        if (emit) begin
            n_phase = PH_IDLE;
            n_acc   = '0;
        end
    end

    // Retire the held byte when it yields nothing or the result slot frees up.
    assign advance    = r_in_valid && (!emit || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_acc       <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
            end
            if (advance && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_source_byte;
        end
        if (advance && emit) begin
            r_out_byte <= emit_byte;
            r_out_bad  <= emit_bad;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_decoded_byte = r_out_byte;
    assign o_bad_escape   = r_out_bad;

    // An error character always carries value zero.
    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_bad |-> r_out_byte == '0)
        else $error("bad escape with nonzero value");

    // Every emitted character returns the decoder to plain text.
    a_emit_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && emit |=> r_phase == PH_IDLE && r_acc == '0)
        else $error("phase not reset after emit");

    // A nonzero accumulator only exists while digits are pending.
    a_acc_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc != '0 |-> (r_phase == PH_OCT2 || r_phase == PH_OCT3 || r_phase == PH_HEX2))
        else $error("accumulator live outside digit phase");

    // A stalled result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |-> !(advance && emit))
        else $error("result register overwritten");

endmodule

`default_nettype wire
